FILE: rtl/gradient_color_lookup_defines.svh
// Assertion macros shared by the gradient color lookup RTL.
`ifndef GRADIENT_COLOR_LOOKUP_DEFINES_SVH
`define GRADIENT_COLOR_LOOKUP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define GCL_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define GCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define GCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gcl_pkg.sv
// Shared types and constants of the gradient color lookup.
`timescale 1ns / 1ps

package gcl_pkg;

  localparam int COLOR_W    = 8;
  localparam int CHANNELS   = 3;
  localparam int COLOR_BITS = COLOR_W * CHANNELS;
  localparam int COUNT_W    = 3;
  localparam int MIN_STOPS  = 2;
  localparam int QUOT_BITS  = COLOR_W;
  localparam int PRE_STAGES = 5;

  localparam int REG_STOP_COUNT     = 0;
  localparam int REG_STOP_WORD_BASE = 1;

  localparam logic [COLOR_BITS-1:0] COLOR_BLACK = '0;
  localparam logic [COLOR_BITS-1:0] COLOR_WHITE = '1;

  typedef logic [COLOR_W-1:0] chan_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: rtl/gcl_pos_if.sv
// Position input channel with valid/ready handshake.
`timescale 1ns / 1ps

interface gcl_pos_if #(
  parameter int POS_W = 17
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

FILE: rtl/gcl_rgb_if.sv
// Color result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface gcl_rgb_if;
  logic           valid;
  logic           ready;
  gcl_pkg::chan_t red;
  gcl_pkg::chan_t green;
  gcl_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/gcl_cfg_if.sv
// Configuration write channel with valid/ready handshake.
`timescale 1ns / 1ps

interface gcl_cfg_if #(
  parameter int IDX_W  = 3,
  parameter int DATA_W = 41
);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gradient_color_lookup.sv
// Pipelined piecewise-linear color gradient lookup, top level.
// One position transaction is accepted per clock while results are taken; the stages
// compare against all stops, pick the stop pair, form the interpolation
// terms, multiply, sum, then an eight-stage restoring divider that settles one
// quotient bit per stage for all three channels. Each stage holds its item only while
// the stage after it is full and stalled, so bubbles close up behind a stalled output.
// Positions above 1.0 are treated as 1.0; stop_count below 2 acts as 2 and above
// MAX_STOPS as MAX_STOPS. The configuration channel is always ready and must be
// written only while no transaction is in flight.
`timescale 1ns / 1ps
`include "gradient_color_lookup_defines.svh"

module gradient_color_lookup #(
  parameter int MAX_STOPS = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  gcl_pos_if.sink   pos,
  gcl_rgb_if.source color,
  gcl_cfg_if.sink   cfg
);

  localparam int POS_W      = FRAC_BITS + 1;
  localparam int COLOR_W    = gcl_pkg::COLOR_W;
  localparam int CHANNELS   = gcl_pkg::CHANNELS;
  localparam int COLOR_BITS = gcl_pkg::COLOR_BITS;
  localparam int COUNT_W    = gcl_pkg::COUNT_W;
  localparam int WORD_W     = POS_W + COLOR_BITS;
  localparam int IDX_W      = $clog2(MAX_STOPS + 1);
  localparam int PROD_W     = COLOR_W + POS_W;
  localparam int NUM_W      = PROD_W + 2;
  localparam int DEN_W      = POS_W + 1;
  localparam int QBITS      = gcl_pkg::QUOT_BITS;
  localparam int NUM_STAGES = gcl_pkg::PRE_STAGES + QBITS;
  localparam int ST_DIV     = gcl_pkg::PRE_STAGES;

  localparam logic [POS_W-1:0]   POS_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(gcl_pkg::MIN_STOPS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_STOPS);

  // configuration registers
  gcl_pkg::count_t   stop_count;
  logic [WORD_W-1:0] stop_word [MAX_STOPS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= COUNT_MIN;
      for (int i = 2; i < MAX_STOPS; i++) begin
        stop_word[i] <= '0;
      end
      stop_word[1] <= {POS_ONE, gcl_pkg::COLOR_WHITE};
      stop_word[0] <= {{POS_W{1'b0}}, gcl_pkg::COLOR_BLACK};
    end else if (cfg.valid) begin
      if (cfg.index == IDX_W'(gcl_pkg::REG_STOP_COUNT)) begin
        stop_count <= cfg.data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg.index == IDX_W'(gcl_pkg::REG_STOP_WORD_BASE + i)) begin
          stop_word[i] <= cfg.data[WORD_W-1:0];
        end
      end
    end
  end

  // pipeline flow control
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   load;
  logic [NUM_STAGES-1:0] vld_in;

  always_comb begin
    load[NUM_STAGES] = color.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign vld_in    = {vld[NUM_STAGES-2:0], pos.valid};
  assign pos.ready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (load[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // stage 1: saturate, clamp count, compare against every stop
  logic [POS_W-1:0]     pos_sat;
  gcl_pkg::count_t      count_clamp;
  logic [MAX_STOPS-1:0] eq_next;
  logic [MAX_STOPS-1:0] lt_next;

  logic [POS_W-1:0]     s1_pos;
  gcl_pkg::count_t      s1_n;
  logic [MAX_STOPS-1:0] s1_eq;
  logic [MAX_STOPS-1:0] s1_lt;

  always_comb begin
    pos_sat = (pos.position > POS_ONE) ? POS_ONE : pos.position;
    if (stop_count < COUNT_MIN) begin
      count_clamp = COUNT_MIN;
    end else if (stop_count > COUNT_MAX) begin
      count_clamp = COUNT_MAX;
    end else begin
      count_clamp = stop_count;
    end
    for (int i = 0; i < MAX_STOPS; i++) begin
      eq_next[i] = (pos_sat == stop_word[i][WORD_W-1 -: POS_W]);
      lt_next[i] = (pos_sat <  stop_word[i][WORD_W-1 -: POS_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_pos <= pos_sat;
      s1_n   <= count_clamp;
      s1_eq  <= eq_next;
      s1_lt  <= lt_next;
    end
  end

  // stage 2: first deciding stop, select the stop pair
  logic [MAX_STOPS-1:0] hit;
  logic [MAX_STOPS-1:0] first;
  logic [MAX_STOPS-1:0] last_oh;
  logic [MAX_STOPS-1:0] lt_up;
  logic [MAX_STOPS-1:0] sel_lo;
  logic [MAX_STOPS-1:0] sel_hi;
  logic                 taken;
  logic [WORD_W-1:0]    lo_next;
  logic [WORD_W-1:0]    hi_next;

  logic [POS_W-1:0]     s2_pos;
  logic [WORD_W-1:0]    s2_lo;
  logic [WORD_W-1:0]    s2_hi;
  logic                 s2_interp;

  always_comb begin
    lt_up = s1_lt >> 1;
    taken = 1'b0;
    first = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      last_oh[i] = (COUNT_W'(i + 1) == s1_n);
      hit[i]     = (COUNT_W'(i) < s1_n) &&
                   (s1_eq[i] || ((COUNT_W'(i + 1) < s1_n) && lt_up[i]));
      first[i]   = hit[i] && !taken;
      taken      = taken || hit[i];
    end
    sel_lo  = first | (taken ? '0 : last_oh);
    sel_hi  = (first & s1_eq) | ((first & ~s1_eq) << 1) | (taken ? '0 : last_oh);
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      lo_next = lo_next | (sel_lo[i] ? stop_word[i] : '0);
      hi_next = hi_next | (sel_hi[i] ? stop_word[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_pos    <= s1_pos;
      s2_lo     <= lo_next;
      s2_hi     <= hi_next;
      s2_interp <= |(first & ~s1_eq);
    end
  end

  // stage 3: interpolation weights; a direct color becomes b with weight one
  logic [POS_W-1:0] bpos;
  logic [POS_W-1:0] epos;
  logic             direct;

  gcl_pkg::chan_t   s3_b [CHANNELS];
  gcl_pkg::chan_t   s3_e [CHANNELS];
  logic [POS_W-1:0] s3_wd;
  logic [POS_W-1:0] s3_dl;
  logic [POS_W-1:0] s3_w;

  always_comb begin
    bpos   = s2_lo[WORD_W-1 -: POS_W];
    epos   = s2_hi[WORD_W-1 -: POS_W];
    direct = !s2_interp || (s2_pos < bpos);
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s3_b[c] <= s2_lo[COLOR_BITS-1-c*COLOR_W -: COLOR_W];
        s3_e[c] <= direct ? s2_lo[COLOR_BITS-1-c*COLOR_W -: COLOR_W]
                          : s2_hi[COLOR_BITS-1-c*COLOR_W -: COLOR_W];
      end
      s3_wd <= direct ? POS_W'(1) : epos - s2_pos;
      s3_dl <= direct ? '0 : s2_pos - bpos;
      s3_w  <= direct ? POS_W'(1) : epos - bpos;
    end
  end

  // stage 4: weighted channel products
  logic [PROD_W-1:0] s4_p0 [CHANNELS];
  logic [PROD_W-1:0] s4_p1 [CHANNELS];
  logic [POS_W-1:0]  s4_w;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s4_p0[c] <= {{POS_W{1'b0}}, s3_b[c]} * {{COLOR_W{1'b0}}, s3_wd};
        s4_p1[c] <= {{POS_W{1'b0}}, s3_e[c]} * {{COLOR_W{1'b0}}, s3_dl};
      end
      s4_w <= s3_w;
    end
  end

  // stage 5: rounding numerator and divisor
  logic [PROD_W:0]  psum [CHANNELS];
  logic [NUM_W-1:0] s5_num [CHANNELS];
  logic [DEN_W-1:0] s5_den;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      psum[c] = {1'b0, s4_p0[c]} + {1'b0, s4_p1[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s5_num[c] <= {psum[c], 1'b0} + {{(NUM_W-POS_W){1'b0}}, s4_w};
      end
      s5_den <= {s4_w, 1'b0};
    end
  end

  // stages 6..13: restoring divider, one quotient bit per stage
  logic [NUM_W-1:0] div_rin [QBITS][CHANNELS];
  gcl_pkg::chan_t   div_qin [QBITS][CHANNELS];
  logic [DEN_W-1:0] div_din [QBITS];
  logic [NUM_W-1:0] div_cmp [QBITS];
  logic             div_ge  [QBITS][CHANNELS];

  logic [NUM_W-1:0] dv_rem [QBITS][CHANNELS];
  gcl_pkg::chan_t   dv_q   [QBITS][CHANNELS];
  logic [DEN_W-1:0] dv_den [QBITS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      div_rin[0][c] = s5_num[c];
      div_qin[0][c] = '0;
    end
    div_din[0] = s5_den;
    for (int j = 1; j < QBITS; j++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        div_rin[j][c] = dv_rem[j-1][c];
        div_qin[j][c] = dv_q[j-1][c];
      end
      div_din[j] = dv_den[j-1];
    end
    for (int j = 0; j < QBITS; j++) begin
      div_cmp[j] = {{(NUM_W-DEN_W){1'b0}}, div_din[j]} << (QBITS - 1 - j);
      for (int c = 0; c < CHANNELS; c++) begin
        div_ge[j][c] = (div_rin[j][c] >= div_cmp[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QBITS; j++) begin
      if (load[ST_DIV+j]) begin
        for (int c = 0; c < CHANNELS; c++) begin
          dv_rem[j][c] <= div_ge[j][c] ? div_rin[j][c] - div_cmp[j] : div_rin[j][c];
          dv_q[j][c]   <= {div_qin[j][c][COLOR_W-2:0], div_ge[j][c]};
        end
        dv_den[j] <= div_din[j];
      end
    end
  end

  assign color.valid = vld[NUM_STAGES-1];
  assign color.red   = dv_q[QBITS-1][0];
  assign color.green = dv_q[QBITS-1][1];
  assign color.blue  = dv_q[QBITS-1][2];

  `GCL_ASSERT_NXT(a_accept_fills_first, clk, rst, pos.valid && pos.ready, vld[0], "accepted transaction did not enter the pipeline")
  `GCL_ASSERT_IMP(a_ready_low_when_full, clk, rst, !pos.ready, vld[0], "input stalled while first stage empty")
  `GCL_ASSERT_IMP(a_width_nonzero, clk, rst, vld[2], s3_w != '0, "interpolation width is zero")
  `GCL_ASSERT_IMP(a_rem_below_den, clk, rst, vld[NUM_STAGES-1], (dv_rem[QBITS-1][0] < NUM_W'(dv_den[QBITS-1])) && (dv_rem[QBITS-1][1] < NUM_W'(dv_den[QBITS-1])) && (dv_rem[QBITS-1][2] < NUM_W'(dv_den[QBITS-1])), "divider remainder not below divisor")

endmodule

FILE: dv/tb_gradient_color_lookup.sv
// Self-checking testbench of the gradient color lookup: directed table, then random gradients.
`timescale 1ns / 1ps

module tb_gradient_color_lookup;

  localparam int MAX_STOPS       = 7;
  localparam int FRAC_BITS       = 16;
  localparam int POS_ONE         = 1 << FRAC_BITS;
  localparam int POS_MAX         = (1 << (FRAC_BITS + 1)) - 1;
  localparam int LATENCY         = 13;
  localparam int IDLE_PERCENT    = 11;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PRINT_LIMIT     = 50;
  localparam int NUM_ROWS        = 34;

  localparam logic [2:0] IDX_COUNT = 3'(gcl_pkg::REG_STOP_COUNT);
  localparam logic [2:0] IDX_WORD0 = 3'(gcl_pkg::REG_STOP_WORD_BASE);

  typedef enum logic {ROW_WRITE, ROW_LOOKUP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [40:0] data;
    logic [16:0] position;
    logic        typed;
    logic [23:0] color;
  } row_t;

  typedef struct packed {
    logic        typed;
    logic [23:0] color;
  } color_plan_t;

  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h00000, 1'b1, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h10000, 1'b1, 24'hFFFFFF},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h1FFFF, 1'b1, 24'hFFFFFF},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h08000, 1'b1, 24'h808080},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h00001, 1'b0, 24'h000000},
    '{ROW_WRITE, IDX_COUNT, 41'd7, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd0, {17'h00000, 24'hFF0080}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd1, {17'h04000, 24'h00FF7F}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd2, {17'h08000, 24'h123456}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd3, {17'h08000, 24'hABCDEF}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd4, {17'h0C000, 24'h000000}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd5, {17'h0E000, 24'hFFFFFF}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd6, {17'h10000, 24'h80FF01}, 17'h0, 1'b0, 24'h0},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h04000, 1'b1, 24'h00FF7F},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h02000, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h08000, 1'b1, 24'h123456},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h0A000, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h07FFF, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h0FFFF, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h10000, 1'b1, 24'h80FF01},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h1FFFF, 1'b1, 24'h80FF01},
    '{ROW_WRITE, IDX_COUNT, 41'd1, 17'h0, 1'b0, 24'h0},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h02000, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h1FFFF, 1'b1, 24'h00FF7F},
    '{ROW_WRITE, IDX_COUNT, 41'd0, 17'h0, 1'b0, 24'h0},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h03000, 1'b0, 24'h000000},
    '{ROW_WRITE, IDX_COUNT, 41'd3, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd0, {17'h08000, 24'h204060}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd1, {17'h04000, 24'hA0C0E0}, 17'h0, 1'b0, 24'h0},
    '{ROW_WRITE, IDX_WORD0 + 3'd2, {17'h0C000, 24'h0F0F0F}, 17'h0, 1'b0, 24'h0},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h01000, 1'b1, 24'h204060},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h08000, 1'b1, 24'h204060},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h06000, 1'b0, 24'h000000},
    '{ROW_LOOKUP, 3'd0, 41'd0, 17'h0E000, 1'b1, 24'h0F0F0F}
  };

  logic clk;
  logic rst;
  bit   steady;
  int   error_count;
  int   quiet_cycles;

  logic [2:0]  stop_total;
  logic [40:0] stop_words [MAX_STOPS];

  logic [23:0] expected_colors [$];
  color_plan_t pending_plans [$];

  string channel_names [gcl_pkg::CHANNELS] = '{"blue", "green", "red"};

  gcl_pos_if pos_ch ();
  gcl_rgb_if rgb_ch ();
  gcl_cfg_if cfg_ch ();

  gradient_color_lookup #(
    .MAX_STOPS(MAX_STOPS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .pos  (pos_ch.sink),
    .color(rgb_ch.source),
    .cfg  (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [7:0] blend_channel(input int lo, input int hi, input longint delta,
                                               input longint span);
    longint num;
    longint den;
    longint q;
    longint v;
    num = 2 * longint'(hi - lo) * delta + span;
    den = 2 * span;
    if (num >= 0) begin
      q = num / den;
    end else begin
      q = -((-num + den - 1) / den);
    end
    v = lo + q;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [23:0] blend_pair(input logic [40:0] lo, input logic [40:0] hi,
                                             input longint p);
    longint bpos;
    longint epos;
    logic [23:0] mixed;
    bpos = lo[40:24];
    epos = hi[40:24];
    if (p < bpos || epos <= bpos) return lo[23:0];
    for (int sh = 0; sh < gcl_pkg::COLOR_BITS; sh += gcl_pkg::COLOR_W) begin
      mixed[sh +: gcl_pkg::COLOR_W] = blend_channel(lo[sh +: gcl_pkg::COLOR_W],
                                                    hi[sh +: gcl_pkg::COLOR_W], p - bpos,
                                                    epos - bpos);
    end
    return mixed;
  endfunction

  function automatic logic [23:0] predict_color(input logic [16:0] raw);
    longint p;
    int n;
    p = raw;
    if (p > POS_ONE) p = POS_ONE;
    n = stop_total;
    if (n < gcl_pkg::MIN_STOPS) n = gcl_pkg::MIN_STOPS;
    if (n > MAX_STOPS) n = MAX_STOPS;
    for (int i = 0; i < n; i++) begin
      if (p == longint'(stop_words[i][40:24])) return stop_words[i][23:0];
      if (i + 1 < n && p < longint'(stop_words[i + 1][40:24])) begin
        return blend_pair(stop_words[i], stop_words[i + 1], p);
      end
    end
    return stop_words[n - 1][23:0];
  endfunction

  function automatic bit in_flight();
    return pending_plans.size() != 0 || expected_colors.size() != 0;
  endfunction

  task automatic send_position(input logic [16:0] pos_value, input bit typed,
                               input logic [23:0] color_value);
    color_plan_t plan;
    plan.typed = typed;
    plan.color = color_value;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      pos_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pending_plans.push_back(plan);
    pos_ch.valid    <= 1'b1;
    pos_ch.position <= pos_value;
    @(posedge clk);
    while (!pos_ch.ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [40:0] value);
    pos_ch.valid <= 1'b0;
    while (in_flight()) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rgb_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rgb_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    logic [23:0] want;
    logic [23:0] got;
    color_plan_t plan;
    if (!rst) begin
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (expected_colors.size() == 0) begin
          report_error("color transaction with no lookup pending");
        end else begin
          want = expected_colors.pop_front();
          got  = {rgb_ch.red, rgb_ch.green, rgb_ch.blue};
          for (int ch = 0; ch < gcl_pkg::CHANNELS; ch++) begin
            if (got[ch*gcl_pkg::COLOR_W +: gcl_pkg::COLOR_W] !==
                want[ch*gcl_pkg::COLOR_W +: gcl_pkg::COLOR_W]) begin
              report_error($sformatf("%s mismatch: got %02h, expected %02h",
                                     channel_names[ch],
                                     got[ch*gcl_pkg::COLOR_W +: gcl_pkg::COLOR_W],
                                     want[ch*gcl_pkg::COLOR_W +: gcl_pkg::COLOR_W]));
            end
          end
        end
      end
      if (pos_ch.valid && pos_ch.ready) begin
        plan = pending_plans.pop_front();
        expected_colors.push_back(plan.typed ? plan.color : predict_color(pos_ch.position));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == IDX_COUNT) begin
          stop_total = cfg_ch.data[2:0];
        end else if (cfg_ch.index - gcl_pkg::REG_STOP_WORD_BASE < MAX_STOPS) begin
          stop_words[cfg_ch.index - gcl_pkg::REG_STOP_WORD_BASE] = cfg_ch.data;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((pos_ch.valid && pos_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("[gradient_color_lookup] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          phase;
    int          item;
    int          count;
    int          n;
    int          k;
    bit          scrambled;
    int          spot [MAX_STOPS];
    logic [31:0] r;
    logic [23:0] hue;
    logic [16:0] p;

    error_count = 0;
    steady      = 1'b0;
    stop_total  = 3'd2;
    foreach (stop_words[i]) stop_words[i] = '0;
    stop_words[1] = {17'(POS_ONE), gcl_pkg::COLOR_WHITE};

    rst             <= 1'b1;
    pos_ch.valid    <= 1'b0;
    pos_ch.position <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED_ROWS[row].kind == ROW_WRITE) begin
        write_register(DIRECTED_ROWS[row].index, DIRECTED_ROWS[row].data);
      end else begin
        send_position(DIRECTED_ROWS[row].position, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].color);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 5);
      case (phase)
        0: count = 2;
        1: count = MAX_STOPS;
        2: count = $urandom_range(0, 1);
        default: count = $urandom_range(0, 7);
      endcase
      n = (count < gcl_pkg::MIN_STOPS) ? gcl_pkg::MIN_STOPS : count;
      scrambled = (phase % 4 == 3);

      // Ordered stops from 0 to 1.0, narrow spans now and then.
      spot[0] = 0;
      for (k = 1; k < MAX_STOPS; k++) begin
        if (k >= n - 1) begin
          spot[k] = POS_ONE;
        end else if ($urandom_range(0, 7) == 0) begin
          spot[k] = spot[k - 1] + 1;
        end else begin
          spot[k] = spot[k - 1] + $urandom_range(0, 2 * (POS_ONE - spot[k - 1]) / (n - k));
        end
        if (spot[k] > POS_ONE) spot[k] = POS_ONE;
      end

      write_register(IDX_COUNT, 41'(count));
      for (k = 0; k < MAX_STOPS; k++) begin
        r   = $urandom();
        hue = r[23:0];
        if (phase == 0 || $urandom_range(0, 3) == 0) begin
          hue = r[24] ? gcl_pkg::COLOR_WHITE : gcl_pkg::COLOR_BLACK;
        end
        if (scrambled || k >= n) begin
          write_register(IDX_WORD0 + 3'(k), {17'($urandom_range(0, POS_MAX)), hue});
        end else begin
          write_register(IDX_WORD0 + 3'(k), {17'(spot[k]), hue});
        end
      end

      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        case ($urandom_range(0, 9))
          0, 1: p = 17'($urandom_range(0, POS_MAX));
          2: p = 17'(stop_words[$urandom_range(0, n - 1)][40:24] + $urandom_range(0, 2) - 1);
          3: p = 17'(POS_ONE);
          default: p = 17'($urandom_range(0, POS_ONE));
        endcase
        send_position(p, 1'b0, '0);
      end
    end

    steady = 1'b0;
    pos_ch.valid <= 1'b0;
    while (in_flight()) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (error_count == 0) begin
      $display("[gradient_color_lookup] OK");
    end else begin
      $display("[gradient_color_lookup] ERROR");
    end
    $finish;
  end

endmodule
